[src/qvr_pkg.sv]
// qvr_pkg: shared constants, types and helpers for the quaternion vector rotator
// no dependencies
`default_nettype none
package qvr_pkg;

	localparam int TRIG_STAGES = 16;
	localparam int ANG_W = 32;
	localparam int TRIG_W = 32;
	localparam int R_W = 28;
	localparam int T_W = 48;
	localparam logic signed [ANG_W-1:0] ANG_PI = 32'sd843314857;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 32'sd421657429;
	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd163008219;

	function automatic logic signed [ANG_W-1:0] atan_q28(input logic [4:0] idx);
		logic signed [ANG_W-1:0] r;
		unique case (idx)
			5'd0: r = 32'sd210828714;
			5'd1: r = 32'sd124459457;
			5'd2: r = 32'sd65760959;
			5'd3: r = 32'sd33381290;
			5'd4: r = 32'sd16755422;
			5'd5: r = 32'sd8385879;
			5'd6: r = 32'sd4193963;
			5'd7: r = 32'sd2097109;
			5'd8: r = 32'sd1048571;
			5'd9: r = 32'sd524287;
			default: r = 32'sd262144 >>> (idx - 5'd10);
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [15:0] ux;
		logic signed [15:0] uy;
		logic signed [15:0] uz;
	} carry_t;

	typedef struct packed {
		logic signed [R_W-1:0] rw;
		logic signed [R_W-1:0] rx;
		logic signed [R_W-1:0] ry;
		logic signed [R_W-1:0] rz;
	} quat_t;

endpackage
`default_nettype wire

[src/qvr_cordic.sv]
// qvr_cordic: pipelined half-angle cordic, one micro-rotation per stage
// depends on qvr_pkg
`default_nettype none
module qvr_cordic (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic signed [15:0] angle,
	input  wire qvr_pkg::carry_t in_carry,
	output logic out_valid,
	output logic signed [qvr_pkg::TRIG_W-1:0] cos_o,
	output logic signed [qvr_pkg::TRIG_W-1:0] sin_o,
	output qvr_pkg::carry_t out_carry
);
	localparam int N = qvr_pkg::TRIG_STAGES;

	logic signed [qvr_pkg::TRIG_W-1:0] x_s [N+1];
	logic signed [qvr_pkg::TRIG_W-1:0] y_s [N+1];
	logic signed [qvr_pkg::ANG_W-1:0] th_s [N+1];
	logic flip_s [N+1];
	logic vld_s [N+1];
	qvr_pkg::carry_t car_s [N+1];

	logic signed [qvr_pkg::ANG_W-1:0] theta;
	// range reduction into [-pi/2, pi/2]
	always_comb begin
		theta = qvr_pkg::ANG_W'(angle) <<< 15;
		flip_s[0] = 1'b0;
		if (theta > qvr_pkg::ANG_HALF_PI) begin
			theta = theta - qvr_pkg::ANG_PI;
			flip_s[0] = 1'b1;
		end else if (theta < -qvr_pkg::ANG_HALF_PI) begin
			theta = theta + qvr_pkg::ANG_PI;
			flip_s[0] = 1'b1;
		end
	end
	assign x_s[0] = qvr_pkg::CORDIC_GAIN;
	assign y_s[0] = '0;
	assign th_s[0] = theta;
	assign vld_s[0] = in_valid;
	assign car_s[0] = in_carry;

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				car_s[i+1] <= car_s[i];
				if (th_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					th_s[i+1] <= th_s[i] - qvr_pkg::atan_q28(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					th_s[i+1] <= th_s[i] + qvr_pkg::atan_q28(5'(i));
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign cos_o = flip_s[N] ? -x_s[N] : x_s[N];
	assign sin_o = flip_s[N] ? -y_s[N] : y_s[N];
	assign out_carry = car_s[N];
endmodule
`default_nettype wire

[src/qvr_hamilton.sv]
// qvr_hamilton: quaternion build and the two hamilton products, pipelined
// depends on qvr_pkg
`default_nettype none
module qvr_hamilton (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic signed [qvr_pkg::TRIG_W-1:0] cos_i,
	input  wire logic signed [qvr_pkg::TRIG_W-1:0] sin_i,
	input  wire qvr_pkg::carry_t in_carry,
	output logic out_valid,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z
);
	localparam int RW = qvr_pkg::R_W;
	localparam int TW = qvr_pkg::T_W;

	// s1: sin*axis products
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [47:0] px_s1, py_s1, pz_s1;
	logic signed [RW-1:0] rw_s1;
	qvr_pkg::carry_t c_s1, c_s2;
	// s2: rounded quaternion
	qvr_pkg::quat_t q_s2, q_s3, q_s4;
	// s3: products for T
	logic signed [63:0] m_s3 [12];
	// s4: T components
	logic signed [TW-1:0] tw_s4, tx_s4, ty_s4, tz_s4;
	// s5: products for Q
	logic signed [79:0] n_s5 [12];
	// s6: saturated results
	logic signed [31:0] ox_s6, oy_s6, oz_s6;

	function automatic logic signed [79:0] rnd24(input logic signed [79:0] v);
		return (v + 80'sd8388608) >>> 24;
	endfunction

	function automatic logic signed [31:0] sat(input logic signed [79:0] v);
		if (v > 80'sd2147483647) return 32'sh7fffffff;
		if (v < -80'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	logic signed [79:0] t0, t1, t2, t3, o0, o1, o2;
	always_comb begin
		t0 = rnd24(-80'(m_s3[0]) - 80'(m_s3[1]) - 80'(m_s3[2]));
		t1 = rnd24(80'(m_s3[3]) + 80'(m_s3[4]) - 80'(m_s3[5]));
		t2 = rnd24(80'(m_s3[6]) - 80'(m_s3[7]) + 80'(m_s3[8]));
		t3 = rnd24(80'(m_s3[9]) + 80'(m_s3[10]) - 80'(m_s3[11]));
		o0 = rnd24(-n_s5[0] + n_s5[1] - n_s5[2] + n_s5[3]);
		o1 = rnd24(-n_s5[4] + n_s5[5] + n_s5[6] - n_s5[7]);
		o2 = rnd24(-n_s5[8] - n_s5[9] + n_s5[10] + n_s5[11]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= {in_valid, v_s1, v_s2, v_s3, v_s4, v_s5};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= 48'(sin_i) * 48'(in_carry.ux);
			py_s1 <= 48'(sin_i) * 48'(in_carry.uy);
			pz_s1 <= 48'(sin_i) * 48'(in_carry.uz);
			rw_s1 <= RW'((48'(cos_i) + 48'sd8) >>> 4);
			c_s1 <= in_carry;
			q_s2.rw <= rw_s1;
			q_s2.rx <= RW'((px_s1 + 48'sd131072) >>> 18);
			q_s2.ry <= RW'((py_s1 + 48'sd131072) >>> 18);
			q_s2.rz <= RW'((pz_s1 + 48'sd131072) >>> 18);
			c_s2 <= c_s1;
			q_s3 <= q_s2;
			m_s3[0] <= 64'(q_s2.rx) * 64'(c_s2.vx);
			m_s3[1] <= 64'(q_s2.ry) * 64'(c_s2.vy);
			m_s3[2] <= 64'(q_s2.rz) * 64'(c_s2.vz);
			m_s3[3] <= 64'(q_s2.rw) * 64'(c_s2.vx);
			m_s3[4] <= 64'(q_s2.ry) * 64'(c_s2.vz);
			m_s3[5] <= 64'(q_s2.rz) * 64'(c_s2.vy);
			m_s3[6] <= 64'(q_s2.rw) * 64'(c_s2.vy);
			m_s3[7] <= 64'(q_s2.rx) * 64'(c_s2.vz);
			m_s3[8] <= 64'(q_s2.rz) * 64'(c_s2.vx);
			m_s3[9] <= 64'(q_s2.rw) * 64'(c_s2.vz);
			m_s3[10] <= 64'(q_s2.rx) * 64'(c_s2.vy);
			m_s3[11] <= 64'(q_s2.ry) * 64'(c_s2.vx);
			q_s4 <= q_s3;
			tw_s4 <= TW'(t0);
			tx_s4 <= TW'(t1);
			ty_s4 <= TW'(t2);
			tz_s4 <= TW'(t3);
			n_s5[0] <= 80'(tw_s4) * 80'(q_s4.rx);
			n_s5[1] <= 80'(tx_s4) * 80'(q_s4.rw);
			n_s5[2] <= 80'(ty_s4) * 80'(q_s4.rz);
			n_s5[3] <= 80'(tz_s4) * 80'(q_s4.ry);
			n_s5[4] <= 80'(tw_s4) * 80'(q_s4.ry);
			n_s5[5] <= 80'(tx_s4) * 80'(q_s4.rz);
			n_s5[6] <= 80'(ty_s4) * 80'(q_s4.rw);
			n_s5[7] <= 80'(tz_s4) * 80'(q_s4.rx);
			n_s5[8] <= 80'(tw_s4) * 80'(q_s4.rz);
			n_s5[9] <= 80'(tx_s4) * 80'(q_s4.ry);
			n_s5[10] <= 80'(ty_s4) * 80'(q_s4.rx);
			n_s5[11] <= 80'(tz_s4) * 80'(q_s4.rw);
			ox_s6 <= sat(o0);
			oy_s6 <= sat(o1);
			oz_s6 <= sat(o2);
		end
	end

	assign out_valid = v_s6;
	assign rot_x = ox_s6;
	assign rot_y = oy_s6;
	assign rot_z = oz_s6;
endmodule
`default_nettype wire

[src/quaternion_vector_rotate_core.sv]
// quaternion_vector_rotate_core: rotates a 3d vector by angle about an axis
// pipeline: 16 cordic stages, then 6 product stages, from input beat to output beat
// throughput: one beat per cycle; the whole pipe advances when the output is free
// the pipe stalls as a unit when the output beat is held by the consumer
// reset: arst_n asynchronous active low clears all stage valid bits
// depends on qvr_pkg, qvr_cordic, qvr_hamilton
`default_nettype none
module quaternion_vector_rotate_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic signed [31:0] vec_x,
	input  wire logic signed [31:0] vec_y,
	input  wire logic signed [31:0] vec_z,
	input  wire logic signed [15:0] angle,
	input  wire logic signed [15:0] axis_x,
	input  wire logic signed [15:0] axis_y,
	input  wire logic signed [15:0] axis_z,
	output logic out_valid,
	input  wire logic out_ready,
	output logic signed [31:0] rot_x,
	output logic signed [31:0] rot_y,
	output logic signed [31:0] rot_z
);
	qvr_pkg::carry_t carry_in, carry_mid;
	logic en, mid_valid;
	logic signed [qvr_pkg::TRIG_W-1:0] cos_w, sin_w;

	// whole pipe moves when the last stage is empty or draining
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	assign carry_in = '{vx: vec_x, vy: vec_y, vz: vec_z, ux: axis_x, uy: axis_y,
		uz: axis_z};

	qvr_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.angle(angle), .in_carry(carry_in), .out_valid(mid_valid),
		.cos_o(cos_w), .sin_o(sin_w), .out_carry(carry_mid)
	);

	qvr_hamilton u_ham (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(mid_valid),
		.cos_i(cos_w), .sin_i(sin_w), .in_carry(carry_mid),
		.out_valid(out_valid), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
	);

	// a held output beat stays valid and keeps its x and y payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rot_x) && $stable(rot_y))
		else $error("output beat changed while stalled");
	// no input taken while output stalled
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted during stall");
	// empty pipe after reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");
endmodule
`default_nettype wire

[bench/qvr_checker.sv]
// qvr_checker: watches both channels of the rotator, predicts each rotated vector
// and compares it with the output beat; depends on nothing but the port widths
`timescale 1ns / 1ps
`default_nettype none
module qvr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic signed [31:0] vec_x,
	input wire logic signed [31:0] vec_y,
	input wire logic signed [31:0] vec_z,
	input wire logic signed [15:0] angle,
	input wire logic signed [15:0] axis_x,
	input wire logic signed [15:0] axis_y,
	input wire logic signed [15:0] axis_z,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic signed [31:0] rot_x,
	input wire logic signed [31:0] rot_y,
	input wire logic signed [31:0] rot_z,
	output int errors,
	output int pending
);

	localparam int STAGES = 16;
	localparam longint HALF_PI_Q28 = 64'sd421657429;
	localparam longint PI_Q28 = 64'sd843314857;
	localparam longint GAIN_Q28 = 64'sd163008219;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vec3_t;

	vec3_t rotated_q[$];

	// arctangent of 2^-i in q28
	function automatic longint atan_step(input int i);
		longint tab[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
			8385879, 4193963, 2097109, 1048571, 524287};
		if (i < 10) begin
			return tab[i];
		end
		return 64'sd262144 >>> (i - 10);
	endfunction

	// round half up then floor by s bits
	function automatic longint rnd(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7fffffff;
		end
		if (v < -64'sd2147483648) begin
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic vec3_t rotate_vec(input longint vx, input longint vy,
		input longint vz, input longint ang, input longint ux, input longint uy,
		input longint uz);
		longint th, cx, cy, nx, c, s, rw, rx, ry, rz, tw, tx, ty, tz;
		bit flip;
		vec3_t r;
		th = ang * 32768;
		flip = 0;
		cx = GAIN_Q28;
		cy = 0;
		if (th > HALF_PI_Q28) begin
			th -= PI_Q28;
			flip = 1;
		end else if (th < -HALF_PI_Q28) begin
			th += PI_Q28;
			flip = 1;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (th >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				th -= atan_step(i);
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				th += atan_step(i);
			end
			cx = nx;
		end
		c = flip ? -cx : cx;
		s = flip ? -cy : cy;
		rw = rnd(c, 4);
		rx = rnd(s * ux, 18);
		ry = rnd(s * uy, 18);
		rz = rnd(s * uz, 18);
		tw = rnd(-rx * vx - ry * vy - rz * vz, 24);
		tx = rnd(rw * vx + ry * vz - rz * vy, 24);
		ty = rnd(rw * vy - rx * vz + rz * vx, 24);
		tz = rnd(rw * vz + rx * vy - ry * vx, 24);
		r.x = clamp32(rnd(-tw * rx + tx * rw - ty * rz + tz * ry, 24));
		r.y = clamp32(rnd(-tw * ry + tx * rz + ty * rw - tz * rx, 24));
		r.z = clamp32(rnd(-tw * rz - tx * ry + ty * rx + tz * rw, 24));
		return r;
	endfunction

	assign pending = rotated_q.size();

	always @(posedge clk or negedge arst_n) begin
		vec3_t e;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (in_valid && in_ready) begin
				rotated_q.push_back(rotate_vec(vec_x, vec_y, vec_z, angle,
					axis_x, axis_y, axis_z));
			end
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					$display("%0t: unexpected beat %h %h %h", $time, rot_x, rot_y, rot_z);
					errors <= errors + 1;
				end else begin
					e = rotated_q.pop_front();
					if (e.x !== rot_x || e.y !== rot_y || e.z !== rot_z) begin
						$display("%0t: mismatch exp %h %h %h got %h %h %h", $time,
							e.x, e.y, e.z, rot_x, rot_y, rot_z);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

[bench/tb.sv]
// tb: stimulus and verdict for quaternion_vector_rotate_core
// depends on the core and on qvr_checker, which does all prediction
`timescale 1ns / 1ps
`default_nettype none
module tb;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_ready = 0;
	logic signed [31:0] vec_x = 0, vec_y = 0, vec_z = 0;
	logic signed [15:0] angle = 0, axis_x = 0, axis_y = 0, axis_z = 0;
	logic in_ready, out_valid;
	logic signed [31:0] rot_x, rot_y, rot_z;
	int errors, pending;
	// percent of cycles the sender idles / the receiver stalls
	int send_idle = 0;
	int recv_stall = 0;
	// stimulus asks once for a long receiver hold-off
	bit hold_req = 0;
	// hold-off state, counted in the receiver process
	bit hold_done = 0;
	int hold_cycles = 0;

	always #1 clk = ~clk;

	quaternion_vector_rotate_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z)
	);

	qvr_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.angle(angle), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
		.errors(errors), .pending(pending)
	);

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_cycles <= 80;
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// offer one beat, idling first at the current rate, and wait for acceptance
	task automatic send_beat(input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input logic [15:0] a, input logic [15:0] ux,
		input logic [15:0] uy, input logic [15:0] uz);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		angle <= a;
		axis_x <= ux;
		axis_y <= uy;
		axis_z <= uz;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	// q2.14 unit-ish axis most of the time, any bits otherwise
	function automatic logic [15:0] axis_comp();
		unique case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(16384) - (($urandom_range(1)) ? 16384 : 0));
			2: return 16'sd16384;
			default: return 16'($signed($urandom_range(0, 16384)) - 8192);
		endcase
	endfunction

	// mostly modest vectors, sometimes full-range or extreme
	function automatic logic [31:0] vec_comp();
		unique case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom) >>> $urandom_range(20, 8);
		endcase
	endfunction

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++) begin
			send_beat(vec_comp(), vec_comp(), vec_comp(), 16'($urandom), axis_comp(),
				axis_comp(), axis_comp());
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int tail;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, quarter turns about each axis, angle extremes,
		// half-angle wrap on both sides, non-unit and zero axis, huge vectors
		send_beat(32'h00010000, 32'h00020000, 32'h00030000, 16'h0000, 16'h4000,
			16'h0000, 16'h0000);
		send_beat(32'h00010000, 0, 0, 16'sd6434, 16'h0000, 16'h0000, 16'h4000);
		send_beat(0, 32'h00010000, 0, 16'sd6434, 16'h4000, 16'h0000, 16'h0000);
		send_beat(0, 0, 32'h00010000, -16'sd6434, 16'h0000, 16'h4000, 16'h0000);
		send_beat(32'h00010000, 32'h00010000, 0, 16'sd12868, 16'h0000, 16'h0000,
			16'h4000);
		send_beat(32'h00010000, 32'h00010000, 0, -16'sd12868, 16'h0000, 16'h0000,
			16'h4000);
		send_beat(32'h00010000, 0, 32'h00010000, 16'sd12869, 16'h0000, 16'h4000,
			16'h0000);
		send_beat(32'h00010000, 0, 32'h00010000, -16'sd12869, 16'h0000, 16'h4000,
			16'h0000);
		send_beat(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff,
			16'h7fff, 16'h7fff, 16'h7fff);
		send_beat(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000,
			16'h8000, 16'h8000, 16'h8000);
		send_beat(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'sd6434,
			16'h8000, 16'h7fff, 16'h8000);
		send_beat(32'h12345678, 32'hfedcba98, 32'h00000001, 16'sd3000, 16'h0000,
			16'h0000, 16'h0000);
		send_beat(32'hffffffff, 32'h00000001, 32'hffffffff, 16'hffff,
			16'h2d41, 16'h2d41, 16'h0000);
		send_beat(32'h00100000, 32'hfff00000, 32'h00080000, 16'h0001,
			16'hffff, 16'h0001, 16'hffff);
		send_beat(32'h00010000, 32'h00010000, 32'h00010000, 16'sd9000,
			16'h24f3, 16'h24f3, 16'h24f3);
		drain();

		// random phases: free flow, idle sender, stalled receiver, both
		send_idle = 0;  recv_stall = 0;  send_random(150);
		send_idle = 77; recv_stall = 0;  send_random(120);
		send_idle = 0;  recv_stall = 77; send_random(120);
		send_idle = 29; recv_stall = 29; send_random(120);

		// sender waits for every outstanding result, then the receiver holds off
		// long enough that the pipe fills and in_ready drops
		drain();
		send_idle = 0; recv_stall = 0;
		hold_req = 1'b1;
		send_random(90);
		drain();

		tail = 0;
		while (tail < 40) begin
			@(posedge clk);
			tail++;
		end
		if (errors == 0 && pending == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("tb failed");
		$finish;
	end

endmodule
`default_nettype wire
